/* rtl/trl_pkg.sv */
// Shared constants, types and helpers of the 2D trilateration block.
package trl_pkg;

	// Field and coordinate widths
	localparam int FRAC_BITS  = 4;
	localparam int COORD_BITS = 16;
	localparam int DIST_W     = 15;
	localparam int OUT_W      = 24;
	localparam int CFG_IDX_W  = 4;

	// Datapath widths
	localparam int RNG_W  = DIST_W + 1;          // corrected range, signed
	localparam int SQ_W   = 2 * RNG_W;           // range squared, signed
	localparam int CSQ_W  = 2 * COORD_BITS;      // coordinate squared, signed
	localparam int DIFF_W = COORD_BITS + 1;      // anchor difference, signed
	localparam int C_W    = CSQ_W + 3;           // right-hand side, signed
	localparam int DET_W  = 2 * DIFF_W + 1;      // determinant, signed
	localparam int P_W    = C_W + DIFF_W;        // cross product, signed
	localparam int N_W    = P_W + 1;             // numerator, signed
	localparam int REM_W  = N_W + FRAC_BITS;     // scaled numerator magnitude
	localparam int Q_W    = OUT_W + 1;           // quotient with overflow bit
	localparam int DSH_W  = DET_W + OUT_W;       // shifted divisor
	localparam int CMP_W  = (REM_W > DSH_W) ? REM_W : DSH_W;
	localparam int N_CELLS = Q_W;

	// Output constants
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0] BELOW_Y = OUT_W'(888) << FRAC_BITS;
	localparam logic [Q_W-1:0] Q_HALF = Q_W'(1) << (OUT_W - 1);

	// Register reset values
	localparam logic signed [COORD_BITS-1:0] RST_A1X = COORD_BITS'(100);
	localparam logic signed [COORD_BITS-1:0] RST_A2Y = COORD_BITS'(100);
	localparam logic [DIST_W-1:0] RST_THRESHOLD = DIST_W'(30);
	localparam logic [DIST_W-1:0] RST_OFFSET    = DIST_W'(40);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANCHOR0_X    = 4'd0,
		REG_ANCHOR0_Y    = 4'd1,
		REG_ANCHOR1_X    = 4'd2,
		REG_ANCHOR1_Y    = 4'd3,
		REG_ANCHOR2_X    = 4'd4,
		REG_ANCHOR2_Y    = 4'd5,
		REG_NEAR_THRESH  = 4'd6,
		REG_RANGE_OFFSET = 4'd7
	} cfg_idx_t;

	// Register write port bundle
	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  idx;
		logic [COORD_BITS-1:0] data;
	} cfg_wr_t;

	// One beat through the divider row, both lanes side by side
	typedef struct packed {
		logic [REM_W-1:0] rem_x;
		logic [REM_W-1:0] rem_y;
		logic [DSH_W-1:0] dsh;
		logic [Q_W-1:0]   quo_x;
		logic [Q_W-1:0]   quo_y;
		logic             neg_x;
		logic             neg_y;
		logic             below;
		logic             degen;
	} div_beat_t;

	// Apply sign to a quotient magnitude and saturate
	function automatic logic signed [OUT_W-1:0] sat_fix(input logic [Q_W-1:0] q,
			input logic neg);
		logic signed [OUT_W-1:0] r;
		if (neg) begin
			if (q > Q_HALF) r = OUT_MIN;
			else r = -$signed(q[OUT_W-1:0]);
		end else begin
			if (q >= Q_HALF) r = OUT_MAX;
			else r = $signed(q[OUT_W-1:0]);
		end
		return r;
	endfunction

endpackage

/* rtl/trl_if.sv */
// Request and response channel interfaces of the trilateration block.
interface trl_req_if import trl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] dist_0;
	logic [DIST_W-1:0] dist_1;
	logic [DIST_W-1:0] dist_2;

	modport source (output valid, output dist_0, output dist_1, output dist_2, input ready);
	modport sink   (input valid, input dist_0, input dist_1, input dist_2, output ready);
endinterface

interface trl_rsp_if import trl_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] pos_x;
	logic signed [OUT_W-1:0] pos_y;
	logic                    below_baseline;
	logic                    degenerate;

	modport source (output valid, output pos_x, output pos_y, output below_baseline,
		output degenerate, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input below_baseline,
		input degenerate, output ready);
endinterface

/* rtl/trilateration_2d.sv */
// Top level of the three-anchor 2D trilateration block.
// Usage:
//   req carries one ranging triple (dist_0..dist_2, cm) per beat; rsp returns
//   one position beat per request: pos_x, pos_y in signed 1/16 cm, plus the
//   below_baseline and degenerate flags. Both channels use valid/ready.
//   Anchors, near threshold and range offset are written through cfg_we,
//   cfg_idx and cfg_data, by the user only while no request is in flight;
//   the block does not enforce it. Out-of-list index writes are dropped.
// Pipeline: 32 registers from the request beat to response valid: six
//   set-up stages (range correction, squares, right-hand side, cross
//   products, numerators, magnitudes), a row of 25 division cells, one
//   quotient bit each, and the response register.
// Throughput: one triple per cycle; every stage and cell takes a new beat
//   in each cycle it is empty or its successor moves.
// Reset: registers return to their reset values and the pipeline empties.
// Stall: while rsp.ready is low, results pile up in the stages behind the
//   response register; req.ready drops only when every stage holds a beat.
module trilateration_2d import trl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [COORD_BITS-1:0] cfg_data,
	trl_req_if.sink               req,
	trl_rsp_if.source             rsp
);

	cfg_wr_t   cfg;
	logic      cv [0:N_CELLS];
	logic      cr [0:N_CELLS];
	div_beat_t cd [0:N_CELLS];

	assign cfg.we   = cfg_we;
	assign cfg.idx  = cfg_idx;
	assign cfg.data = cfg_data;

	trl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.out_valid (cv[0]),
		.out_data  (cd[0]),
		.out_ready (cr[0])
	);

	// Division row
	for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
		trl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[g]),
			.in_data   (cd[g]),
			.in_ready  (cr[g]),
			.out_valid (cv[g+1]),
			.out_data  (cd[g+1]),
			.out_ready (cr[g+1])
		);
	end

	trl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cv[N_CELLS]),
		.in_data  (cd[N_CELLS]),
		.in_ready (cr[N_CELLS]),
		.rsp      (rsp)
	);

`ifndef SYNTH
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.degenerate |-> rsp.pos_x == '0 && rsp.pos_y == '0)
		else $error("degenerate result with nonzero position");

	a_degen_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.degenerate |-> !rsp.below_baseline)
		else $error("degenerate and below_baseline both set");

	a_below_y: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.below_baseline |-> rsp.pos_y == BELOW_Y)
		else $error("below_baseline without substituted y");

	a_row_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cr[N_CELLS] |-> rsp.valid && !rsp.ready)
		else $error("division row stalled without a waiting response");
`endif

endmodule

/* rtl/trl_front.sv */
// Register file, range correction and linear-system set-up ahead of the divider row.
module trl_front import trl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_wr_t    cfg,
	trl_req_if.sink    req,
	output logic       out_valid,
	output div_beat_t  out_data,
	input  logic       out_ready
);

	// Configuration registers
	logic signed [COORD_BITS-1:0] a0x_q, a0y_q, a1x_q, a1y_q, a2x_q, a2y_q;
	logic [DIST_W-1:0] thr_q, ofs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a0x_q <= '0;
			a0y_q <= '0;
			a1x_q <= RST_A1X;
			a1y_q <= '0;
			a2x_q <= '0;
			a2y_q <= RST_A2Y;
			thr_q <= RST_THRESHOLD;
			ofs_q <= RST_OFFSET;
		end else if (cfg.we) begin
			unique case (cfg_idx_t'(cfg.idx))
				REG_ANCHOR0_X:    a0x_q <= cfg.data;
				REG_ANCHOR0_Y:    a0y_q <= cfg.data;
				REG_ANCHOR1_X:    a1x_q <= cfg.data;
				REG_ANCHOR1_Y:    a1y_q <= cfg.data;
				REG_ANCHOR2_X:    a2x_q <= cfg.data;
				REG_ANCHOR2_Y:    a2y_q <= cfg.data;
				REG_NEAR_THRESH:  thr_q <= cfg.data[DIST_W-1:0];
				REG_RANGE_OFFSET: ofs_q <= cfg.data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// Anchor terms, registered from the configuration registers
	logic signed [DIFF_W-1:0] ea1_q, eb1_q, ea2_q, eb2_q;
	logic signed [CSQ_W-1:0]  xx0_q, yy0_q, xx1_q, yy1_q, xx2_q, yy2_q;
	logic signed [DET_W-1:0]  det_q;
	logic signed [C_W-1:0]    k1_q, k2_q;
	logic [DET_W-1:0]         dmag_q;
	logic                     den_neg_q, det_zero_q;
	logic signed [DET_W:0]    den_w;

	assign den_w = {det_q, 1'b0};

	always_ff @(posedge clk) begin
		ea1_q <= DIFF_W'(a1x_q) - DIFF_W'(a0x_q);
		eb1_q <= DIFF_W'(a1y_q) - DIFF_W'(a0y_q);
		ea2_q <= DIFF_W'(a2x_q) - DIFF_W'(a0x_q);
		eb2_q <= DIFF_W'(a2y_q) - DIFF_W'(a0y_q);
		xx0_q <= a0x_q * a0x_q;
		yy0_q <= a0y_q * a0y_q;
		xx1_q <= a1x_q * a1x_q;
		yy1_q <= a1y_q * a1y_q;
		xx2_q <= a2x_q * a2x_q;
		yy2_q <= a2y_q * a2y_q;
		det_q <= DET_W'(ea1_q * eb2_q) - DET_W'(ea2_q * eb1_q);
		k1_q  <= C_W'(xx1_q) + C_W'(yy1_q) - C_W'(xx0_q) - C_W'(yy0_q);
		k2_q  <= C_W'(xx2_q) + C_W'(yy2_q) - C_W'(xx0_q) - C_W'(yy0_q);
		den_neg_q  <= den_w[DET_W];
		det_zero_q <= (det_q == '0);
		dmag_q     <= den_w[DET_W] ? DET_W'(-den_w) : DET_W'(den_w);
	end

	// Stage handshake: a stage moves when empty or when the next one moves
	localparam int NST = 6;
	logic [NST-1:0] v_q;
	logic [NST-1:0] adv;

	always_comb begin
		adv[NST-1] = !v_q[NST-1] || out_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			adv[k] = !v_q[k] || adv[k+1];
		end
	end

	assign req.ready = adv[0];
	assign out_valid = v_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0]) v_q[0] <= req.valid;
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	// Range correction
	function automatic logic signed [RNG_W-1:0] correct(input logic [DIST_W-1:0] d,
			input logic [DIST_W-1:0] thr, input logic [DIST_W-1:0] ofs);
		logic signed [RNG_W-1:0] r;
		if (d < thr) r = $signed({1'b0, d});
		else r = $signed({1'b0, d}) - $signed({1'b0, ofs});
		return r;
	endfunction

	logic signed [RNG_W-1:0] r0_s1, r1_s1, r2_s1;
	logic signed [SQ_W-1:0]  q0_s2, q1_s2, q2_s2;
	logic signed [C_W-1:0]   c1_s3, c2_s3;
	logic signed [P_W-1:0]   pxa_s4, pxb_s4, pya_s4, pyb_s4;
	logic signed [N_W-1:0]   nx_s5, ny_s5;
	div_beat_t               beat_s6;
	div_beat_t               beat_w;
	logic [N_W-1:0]          mx_w, my_w;

	// Build the divider beat from the numerators
	always_comb begin
		mx_w = nx_s5[N_W-1] ? N_W'(-nx_s5) : N_W'(nx_s5);
		my_w = ny_s5[N_W-1] ? N_W'(-ny_s5) : N_W'(ny_s5);
		beat_w.rem_x = {mx_w, {FRAC_BITS{1'b0}}};
		beat_w.rem_y = {my_w, {FRAC_BITS{1'b0}}};
		beat_w.dsh   = {dmag_q, {OUT_W{1'b0}}};
		beat_w.quo_x = '0;
		beat_w.quo_y = '0;
		beat_w.neg_x = nx_s5[N_W-1] ^ den_neg_q;
		beat_w.neg_y = ny_s5[N_W-1] ^ den_neg_q;
		beat_w.below = !det_zero_q && (ny_s5 != '0) && (ny_s5[N_W-1] != den_neg_q);
		beat_w.degen = det_zero_q;
	end

	// Advance the payload stages
	always_ff @(posedge clk) begin
		if (adv[0] && req.valid) begin
			r0_s1 <= correct(req.dist_0, thr_q, ofs_q);
			r1_s1 <= correct(req.dist_1, thr_q, ofs_q);
			r2_s1 <= correct(req.dist_2, thr_q, ofs_q);
		end
		if (adv[1] && v_q[0]) begin
			q0_s2 <= r0_s1 * r0_s1;
			q1_s2 <= r1_s1 * r1_s1;
			q2_s2 <= r2_s1 * r2_s1;
		end
		if (adv[2] && v_q[1]) begin
			c1_s3 <= C_W'(q0_s2) - C_W'(q1_s2) + k1_q;
			c2_s3 <= C_W'(q0_s2) - C_W'(q2_s2) + k2_q;
		end
		if (adv[3] && v_q[2]) begin
			pxa_s4 <= c1_s3 * eb2_q;
			pxb_s4 <= c2_s3 * eb1_q;
			pya_s4 <= ea1_q * c2_s3;
			pyb_s4 <= ea2_q * c1_s3;
		end
		if (adv[4] && v_q[3]) begin
			nx_s5 <= N_W'(pxa_s4) - N_W'(pxb_s4);
			ny_s5 <= N_W'(pya_s4) - N_W'(pyb_s4);
		end
		if (adv[5] && v_q[4]) begin
			beat_s6 <= beat_w;
		end
	end

	assign out_data = beat_s6;

endmodule

/* rtl/trl_cell.sv */
// One restoring-division cell: one quotient bit for each lane per beat.
module trl_cell import trl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  div_beat_t in_data,
	output logic      in_ready,
	output logic      out_valid,
	output div_beat_t out_data,
	input  logic      out_ready
);

	logic      v_q;
	div_beat_t beat_q;
	div_beat_t nxt;
	logic [CMP_W-1:0] dsh_w, rx_w, ry_w;
	logic ge_x, ge_y;

	// Trial subtract on both lanes, shift the divisor for the next cell
	always_comb begin
		dsh_w = CMP_W'(in_data.dsh);
		rx_w  = CMP_W'(in_data.rem_x);
		ry_w  = CMP_W'(in_data.rem_y);
		ge_x  = rx_w >= dsh_w;
		ge_y  = ry_w >= dsh_w;
		nxt       = in_data;
		nxt.rem_x = ge_x ? REM_W'(rx_w - dsh_w) : in_data.rem_x;
		nxt.rem_y = ge_y ? REM_W'(ry_w - dsh_w) : in_data.rem_y;
		nxt.quo_x = {in_data.quo_x[Q_W-2:0], ge_x};
		nxt.quo_y = {in_data.quo_y[Q_W-2:0], ge_y};
		nxt.dsh   = in_data.dsh >> 1;
	end

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_data  = beat_q;

	// Hold while stalled, else take the next beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_q <= nxt;
		end
	end

endmodule

/* rtl/trl_back.sv */
// Sign, saturation and special-case selection into the response register.
module trl_back import trl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  div_beat_t in_data,
	output logic      in_ready,
	trl_rsp_if.source rsp
);

	logic                    v_q;
	logic signed [OUT_W-1:0] px_q, py_q;
	logic                    below_q, degen_q;
	logic signed [OUT_W-1:0] px_w, py_w;

	// Pick the final coordinates
	always_comb begin
		px_w = sat_fix(in_data.quo_x, in_data.neg_x);
		py_w = in_data.below ? BELOW_Y : sat_fix(in_data.quo_y, in_data.neg_y);
		if (in_data.degen) begin
			px_w = '0;
			py_w = '0;
		end
	end

	assign in_ready = !v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			px_q    <= px_w;
			py_q    <= py_w;
			below_q <= in_data.below;
			degen_q <= in_data.degen;
		end
	end

	assign rsp.valid          = v_q;
	assign rsp.pos_x          = px_q;
	assign rsp.pos_y          = py_q;
	assign rsp.below_baseline = below_q;
	assign rsp.degenerate     = degen_q;

endmodule

/* tb/sv/trilateration_2d_tb.sv */
// Self-checking regression of the three-anchor 2D trilateration block.
module trilateration_2d_tb;
	import trl_pkg::*;

	typedef struct {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic                    below;
		logic                    degen;
	} fix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [COORD_BITS-1:0] cfg_data = '0;

	trl_req_if req ();
	trl_rsp_if rsp ();

	trilateration_2d dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
	);

	// Shadow registers of the block
	logic signed [COORD_BITS-1:0] ax [3];
	logic signed [COORD_BITS-1:0] ay [3];
	logic [DIST_W-1:0] thresh, offs;

	fix_t pending_pos [$];
	int errors = 0;
	int n_sent = 0, n_recv = 0, n_below = 0, n_degen = 0;
	int src_idle = 0, snk_stall = 0;
	bit hold_off = 0;
	int idle_cnt = 0;

	always #2 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.dist_0 = '0;
		req.dist_1 = '0;
		req.dist_2 = '0;
		rsp.ready = 1'b0;
	end

	function automatic longint corr(logic [DIST_W-1:0] d);
		longint v;
		v = d;
		if (v < longint'(thresh)) return v;
		return v - longint'(offs);
	endfunction

	function automatic longint clip24(longint v);
		if (v > longint'(OUT_MAX)) return longint'(OUT_MAX);
		if (v < longint'(OUT_MIN)) return longint'(OUT_MIN);
		return v;
	endfunction

	function automatic longint scaled_quot(longint num, longint den);
		longint q, r, lim;
		q = num / den;
		r = num % den;
		lim = (longint'(1) << 23) / (longint'(1) << FRAC_BITS) + 1;
		if (q > lim) return longint'(OUT_MAX);
		if (q < -lim) return longint'(OUT_MIN);
		return clip24(q * (1 << FRAC_BITS) + (r * (1 << FRAC_BITS)) / den);
	endfunction

	function automatic fix_t solve_pos(logic [DIST_W-1:0] d0, logic [DIST_W-1:0] d1,
			logic [DIST_W-1:0] d2);
		fix_t p;
		longint x0, y0, x1, y1, x2, y2, r0, r1, r2, a1, b1, a2, b2, p0, c1, c2, det;
		longint den, nx, ny;
		x0 = ax[0]; y0 = ay[0]; x1 = ax[1]; y1 = ay[1]; x2 = ax[2]; y2 = ay[2];
		r0 = corr(d0); r1 = corr(d1); r2 = corr(d2);
		a1 = x1 - x0; b1 = y1 - y0; a2 = x2 - x0; b2 = y2 - y0;
		p0 = x0 * x0 + y0 * y0;
		c1 = r0 * r0 - r1 * r1 + x1 * x1 + y1 * y1 - p0;
		c2 = r0 * r0 - r2 * r2 + x2 * x2 + y2 * y2 - p0;
		det = a1 * b2 - a2 * b1;
		p = '{x: '0, y: '0, below: 1'b0, degen: 1'b0};
		if (det == 0) begin
			p.degen = 1'b1;
		end else begin
			den = 2 * det;
			nx = c1 * b2 - c2 * b1;
			ny = a1 * c2 - a2 * c1;
			p.x = OUT_W'(scaled_quot(nx, den));
			if (ny != 0 && ((ny < 0) != (den < 0))) begin
				p.below = 1'b1;
				p.y = BELOW_Y;
			end else begin
				p.y = OUT_W'(scaled_quot(ny, den));
			end
		end
		return p;
	endfunction

	// Write one register and mirror it
	task automatic write_reg(cfg_idx_t idx, logic [COORD_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_ANCHOR0_X: ax[0] = val;
			REG_ANCHOR0_Y: ay[0] = val;
			REG_ANCHOR1_X: ax[1] = val;
			REG_ANCHOR1_Y: ay[1] = val;
			REG_ANCHOR2_X: ax[2] = val;
			REG_ANCHOR2_Y: ay[2] = val;
			REG_NEAR_THRESH: thresh = val[DIST_W-1:0];
			REG_RANGE_OFFSET: offs = val[DIST_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Out-of-list index: the block must drop it
	task automatic write_bad_idx(logic [COORD_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_IDX_W'(8 + $urandom_range(0, 7));
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_anchors(int x0, int y0, int x1, int y1, int x2, int y2);
		write_reg(REG_ANCHOR0_X, COORD_BITS'(x0));
		write_reg(REG_ANCHOR0_Y, COORD_BITS'(y0));
		write_reg(REG_ANCHOR1_X, COORD_BITS'(x1));
		write_reg(REG_ANCHOR1_Y, COORD_BITS'(y1));
		write_reg(REG_ANCHOR2_X, COORD_BITS'(x2));
		write_reg(REG_ANCHOR2_Y, COORD_BITS'(y2));
	endtask

	// Send one ranging triple; valid stays high across back-to-back beats
	task automatic send_range(logic [DIST_W-1:0] d0, logic [DIST_W-1:0] d1,
			logic [DIST_W-1:0] d2);
		while ($urandom_range(0, 99) < src_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.dist_0 <= d0;
		req.dist_1 <= d1;
		req.dist_2 <= d2;
		pending_pos.push_back(solve_pos(d0, d1, d2));
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		n_sent++;
	endtask

	// Lower valid and wait until every position has come back
	task automatic drain;
		req.valid <= 1'b0;
		while (pending_pos.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [DIST_W-1:0] rand_dist;
		case ($urandom_range(0, 5))
			0: return DIST_W'($urandom_range(0, 60));
			1: return '1;
			2: return DIST_W'($urandom);
			default: return DIST_W'($urandom_range(0, 400));
		endcase
	endfunction

	// Receiver readiness, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_off) rsp.ready <= 1'b0;
		else rsp.ready <= ($urandom_range(0, 99) >= snk_stall);
	end

	// Check each position beat against the oldest prediction
	always @(posedge clk) begin
		fix_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			n_recv++;
			if (pending_pos.size() == 0) begin
				$display("%0t: unexpected beat x=%0d y=%0d", $time, rsp.pos_x, rsp.pos_y);
				errors++;
			end else begin
				e = pending_pos.pop_front();
				if (rsp.degenerate) n_degen++;
				if (rsp.below_baseline) n_below++;
				if (rsp.pos_x !== e.x || rsp.pos_y !== e.y ||
						rsp.below_baseline !== e.below || rsp.degenerate !== e.degen) begin
					$display("%0t: mismatch exp %0d/%0d/%0b/%0b act %0d/%0d/%0b/%0b",
						$time, e.x, e.y, e.below, e.degen,
						rsp.pos_x, rsp.pos_y, rsp.below_baseline, rsp.degenerate);
					errors++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || hold_off || cfg_we)
			idle_cnt <= 0;
		else if (arst_n) idle_cnt <= idle_cnt + 1;
		if (idle_cnt > 20000) begin
			$display("trilateration_2d regression: fail");
			$finish;
		end
	end

	task automatic test_reset_defaults;
		send_range(0, 0, 0);
		send_range(29, 30, 31);
		send_range(50, 100, 100);
		send_range(DIST_W'(32767), 0, 0);
		drain();
		write_bad_idx(16'hFFFF);
		send_range(70, 90, 120);
		drain();
	endtask

	task automatic test_directed_cases;
		send_range(10, 200, 200);
		send_range(200, 10, 10);
		send_range(0, 32767, 32767);
		send_range(32767, 32767, 0);
		drain();
		set_anchors(-32768, -32768, 32767, 32767, -32768, 32767);
		write_reg(REG_NEAR_THRESH, 16'h7FFF);
		write_reg(REG_RANGE_OFFSET, 16'h7FFF);
		drain();
		send_range(32767, 0, 32767);
		send_range(0, 32767, 0);
		send_range(32766, 1, 16000);
		drain();
		write_reg(REG_NEAR_THRESH, 16'd0);
		drain();
		send_range(0, 0, 0);
		send_range(32767, 100, 5);
		drain();
		set_anchors(0, 0, 1, 0, 2, 0);
		drain();
		send_range(50, 60, 70);
		drain();
		set_anchors(0, 0, 1, 0, 0, 1);
		write_reg(REG_RANGE_OFFSET, 16'd0);
		drain();
		send_range(32767, 0, 0);
		send_range(0, 32767, 32767);
		send_range(1, 1, 1);
		drain();
	endtask

	task automatic random_phase(int n, int idle_p, int stall_p);
		src_idle = idle_p;
		snk_stall = stall_p;
		repeat (n) send_range(rand_dist(), rand_dist(), rand_dist());
		drain();
		src_idle = 0;
		snk_stall = 0;
	endtask

	task automatic random_config;
		int k;
		k = $urandom_range(0, 3);
		if (k == 0) set_anchors(0, 0, 100, 0, 0, 100);
		else if (k == 1) set_anchors($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
			$urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
			$urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200);
		else if (k == 2) set_anchors($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		else set_anchors(0, 0, 300, 0, 600, 0);
		write_reg(REG_NEAR_THRESH,
			$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 80)));
		write_reg(REG_RANGE_OFFSET,
			$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 80)));
	endtask

	task automatic test_random_traffic;
		random_config(); random_phase(180, 0, 0);
		random_config(); random_phase(180, 53, 0);
		random_config(); random_phase(180, 0, 53);
		random_config(); random_phase(180, 6, 6);
		random_config(); random_phase(150, 30, 30);
	endtask

	// Hold the receiver off so the pipeline fills and req.ready drops
	task automatic test_back_pressure;
		fork
			begin
				hold_off = 1;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			repeat (60) send_range(rand_dist(), rand_dist(), rand_dist());
		join
		drain();
	endtask

	initial begin
		ax[0] = 0; ay[0] = 0; ax[1] = RST_A1X; ay[1] = 0; ax[2] = 0; ay[2] = RST_A2Y;
		thresh = RST_THRESHOLD;
		offs = RST_OFFSET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_defaults();
		test_directed_cases();
		test_back_pressure();
		test_random_traffic();
		$display("covered %0d triples, %0d positions, %0d below baseline, %0d degenerate",
			n_sent, n_recv, n_below, n_degen);
		$display("across register extremes, idle and stall phases and a long hold-off");
		if (errors == 0 && pending_pos.size() == 0) begin
			$display("trilateration_2d regression: pass");
		end else begin
			$display("trilateration_2d regression: fail");
		end
		$finish;
	end
endmodule
